@@ hw/rtl/ctq_pkg.sv @@
// Shared types and constants for the CAN transmit queue with id packing.
// No dependencies.
package ctq_pkg;

   localparam int unsigned QUEUE_SLOTS_DEF = 16;
   localparam int unsigned CMD_DEPTH       = 2;
   localparam int unsigned CMD_PTR_W       = $clog2(CMD_DEPTH);
   localparam int unsigned CMD_CNT_W       = $clog2(CMD_DEPTH + 1);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_SEND = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      FMT_STD_DATA   = 2'd0,
      FMT_STD_REMOTE = 2'd1,
      FMT_EXT_DATA   = 2'd2,
      FMT_EXT_REMOTE = 2'd3
   } fmt_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_PACK = 1'b1
   } state_type;

   typedef struct packed {
      logic        opcode;
      logic [28:0] std_id;
      logic [28:0] ext_id;
      logic [3:0]  frame_len;
      logic [31:0] data_low;
      logic [31:0] data_high;
      logic [1:0]  tx_format;
      logic        controller_busy;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        send_valid;
      logic [31:0] id_word;
      logic [3:0]  length_word;
      logic [31:0] word_one;
      logic [31:0] word_two;
      logic        queue_empty;
      logic        queue_full;
      logic [28:0] last_sent_id;
   } rsp_type;

   // Classified request handed from the front end to the back end.
   typedef struct packed {
      op_type  op;
      req_type req;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

@@ hw/rtl/ctq_front.sv @@
// Front end: accepts requests, classifies them, and buffers them in a
// short command queue for the back end. Depends on ctq_pkg.
module ctq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ctq_pkg::req_type      req_data,
   output ctq_pkg::cmd_chan_type cmd_out,
   input  logic                  cmd_pop
);

   ctq_pkg::cmd_type                  cq_mem [ctq_pkg::CMD_DEPTH];
   logic [ctq_pkg::CMD_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ctq_pkg::CMD_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ctq_pkg::CMD_CNT_W-1:0]     count_ff, count_in;
   logic                              push;
   logic                              pop;
   ctq_pkg::cmd_type                  cmd_new;

   assign busy = (count_ff == ctq_pkg::CMD_CNT_W'(ctq_pkg::CMD_DEPTH));
   assign push = start && !busy;
   assign pop  = cmd_pop && (count_ff != '0);

   always_comb begin
      cmd_new.req = req_data;
      cmd_new.op  = req_data.opcode ? ctq_pkg::OP_SEND : ctq_pkg::OP_PUSH;
   end

   function automatic logic [ctq_pkg::CMD_PTR_W-1:0] ptr_next(
      input logic [ctq_pkg::CMD_PTR_W-1:0] p);
      if (p == ctq_pkg::CMD_PTR_W'(ctq_pkg::CMD_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cq_mem[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_out.valid = (count_ff != '0);
   assign cmd_out.cmd   = cq_mem[rd_ptr_ff];

endmodule

@@ hw/rtl/ctq_back.sv @@
// Back end: message ring buffer, push/send execution, id packing and
// registered response. Depends on ctq_pkg.
module ctq_back #(
   parameter int unsigned QUEUE_SLOTS = ctq_pkg::QUEUE_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctq_pkg::cmd_chan_type cmd_in,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   output ctq_pkg::rsp_type      rsp_data
);

   localparam int unsigned IDX_W = $clog2(QUEUE_SLOTS);

   typedef struct packed {
      logic [28:0] std_id;
      logic [28:0] ext_id;
      logic [3:0]  frame_len;
      logic [31:0] data_low;
      logic [31:0] data_high;
   } slot_type;

   slot_type                mem [QUEUE_SLOTS];
   slot_type                mem_rd_ff;
   logic                    mem_wr_en;
   logic                    mem_rd_en;
   slot_type                mem_wr_data;

   ctq_pkg::state_type      state_ff, state_in;
   logic [IDX_W-1:0]        wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [28:0]             sent_id_ff, sent_id_in;
   logic [1:0]              fmt_ff, fmt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ctq_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                    is_send;
   logic                    can_push;
   logic                    can_send;

   function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
      if (i == IDX_W'(QUEUE_SLOTS - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   function automatic logic [31:0] pack_id(input logic [1:0] fmt,
                                           input logic [28:0] sid,
                                           input logic [28:0] eid);
      logic [31:0] ext_part;
      ext_part = {1'b0, eid[17:0], 2'b00, eid[28:18]};
      case (fmt)
         ctq_pkg::FMT_STD_DATA:   return {21'd0, sid[10:0]};
         ctq_pkg::FMT_STD_REMOTE: return {20'd0, 1'b1, sid[10:0]};
         ctq_pkg::FMT_EXT_DATA:   return ext_part | 32'h0000_1800;
         default:                 return ext_part | 32'h8000_1000;
      endcase
   endfunction

   assign is_send  = (cmd_in.cmd.op == ctq_pkg::OP_SEND);
   assign can_push = (slot_next(wr_idx_ff) != rd_idx_ff);
   assign can_send = !cmd_in.cmd.req.controller_busy && (wr_idx_ff != rd_idx_ff);
   assign cmd_pop  = (state_ff == ctq_pkg::ST_IDLE) && cmd_in.valid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctq_pkg::ST_IDLE: begin
            if (cmd_in.valid && is_send && can_send) begin
               state_in = ctq_pkg::ST_PACK;
            end
         end
         ctq_pkg::ST_PACK: state_in = ctq_pkg::ST_IDLE;
         default:          state_in = ctq_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      sent_id_in   = sent_id_ff;
      fmt_in       = fmt_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_wr_data.std_id    = cmd_in.cmd.req.std_id;
      mem_wr_data.ext_id    = cmd_in.cmd.req.ext_id;
      mem_wr_data.frame_len = cmd_in.cmd.req.frame_len;
      mem_wr_data.data_low  = cmd_in.cmd.req.data_low;
      mem_wr_data.data_high = cmd_in.cmd.req.data_high;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      case (state_ff)
         ctq_pkg::ST_IDLE: begin
            if (cmd_in.valid) begin
               if (!is_send) begin
                  if (can_push) begin
                     mem_wr_en = 1'b1;
                     wr_idx_in = slot_next(wr_idx_ff);
                  end
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.accepted     = can_push;
                  rsp_data_in.queue_empty  = (wr_idx_in == rd_idx_ff);
                  rsp_data_in.queue_full   = (slot_next(wr_idx_in) == rd_idx_ff);
                  rsp_data_in.last_sent_id = sent_id_ff;
               end else if (can_send) begin
                  mem_rd_en = 1'b1;
                  rd_idx_in = slot_next(rd_idx_ff);
                  fmt_in    = cmd_in.cmd.req.tx_format;
               end else begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.queue_empty  = (wr_idx_ff == rd_idx_ff);
                  rsp_data_in.queue_full   = (slot_next(wr_idx_ff) == rd_idx_ff);
                  rsp_data_in.last_sent_id = sent_id_ff;
               end
            end
         end
         ctq_pkg::ST_PACK: begin
            sent_id_in               = mem_rd_ff.std_id;
            rsp_valid_in             = 1'b1;
            rsp_data_in.accepted     = 1'b1;
            rsp_data_in.send_valid   = 1'b1;
            rsp_data_in.id_word      = pack_id(fmt_ff, mem_rd_ff.std_id, mem_rd_ff.ext_id);
            rsp_data_in.length_word  = mem_rd_ff.frame_len;
            rsp_data_in.word_one     = mem_rd_ff.data_low;
            rsp_data_in.word_two     = mem_rd_ff.data_high;
            rsp_data_in.queue_empty  = (wr_idx_ff == rd_idx_ff);
            rsp_data_in.queue_full   = (slot_next(wr_idx_ff) == rd_idx_ff);
            rsp_data_in.last_sent_id = mem_rd_ff.std_id;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctq_pkg::ST_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         sent_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         sent_id_ff   <= sent_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fmt_ff      <= fmt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[wr_idx_ff] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         mem_rd_ff <= mem[rd_idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/can_tx_queue_with_id_packing_top.sv @@
// Top level of the CAN transmit queue with id packing.
// Instantiates ctq_front and ctq_back; types from ctq_pkg.
//
// A request is taken when start is high and busy is low; it enters a
// two-entry command queue, so requests can be taken on consecutive cycles
// until that queue fills. Each request gives exactly one response, shown
// on rsp_data for one cycle while rsp_valid is high; the receiver cannot
// stall it. A push, a refused push and a send that pops nothing answer
// in the cycle after the back end takes the command; a send that pops a
// message answers through the registered read port of the message slot
// memory and then the response register, and the back end takes no new
// command meanwhile. The ring holds QUEUE_SLOTS - 1 messages.
module can_tx_queue_with_id_packing_top #(
   parameter int unsigned QUEUE_SLOTS = ctq_pkg::QUEUE_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ctq_pkg::req_type req_data,
   output logic             rsp_valid,
   output ctq_pkg::rsp_type rsp_data
);

   ctq_pkg::cmd_chan_type cmd_chan;
   logic                  cmd_pop;

   ctq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .cmd_out  (cmd_chan),
      .cmd_pop  (cmd_pop)
   );

   ctq_back #(
      .QUEUE_SLOTS (QUEUE_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (cmd_chan),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_sent_is_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_valid |-> rsp_data.accepted)
      else $error("sent frame without accepted");

   a_empty_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.queue_empty && rsp_data.queue_full))
      else $error("queue both empty and full");

   a_no_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_valid |->
         rsp_data.id_word == '0 && rsp_data.word_one == '0 && rsp_data.word_two == '0)
      else $error("frame words not cleared");

   a_std_id_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_valid && !rsp_data.id_word[12] |->
         rsp_data.id_word[10:0] == rsp_data.last_sent_id[10:0])
      else $error("packed standard id differs from last sent id");

   a_sent_leaves_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_valid |-> !rsp_data.queue_full)
      else $error("queue full right after a pop");

endmodule
